// File: rtl/core/mer_pkg.sv
// Shared types and codes for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    typedef logic [1:0] phase_t;
    typedef logic [3:0] state_t;
    typedef logic [1:0] emit_idx_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam phase_t PH_IDLE = 2'd0;
    localparam phase_t PH_R1   = 2'd1;
    localparam phase_t PH_R2   = 2'd2;
    localparam phase_t PH_DONE = 2'd3;

    localparam state_t ST_IDLE   = 4'd0;
    localparam state_t ST_SQX    = 4'd1;
    localparam state_t ST_SQY    = 4'd2;
    localparam state_t ST_ARY    = 4'd3;
    localparam state_t ST_AOY    = 4'd4;
    localparam state_t ST_UPD    = 4'd5;
    localparam state_t ST_ADDX   = 4'd6;
    localparam state_t ST_SUBY   = 4'd7;
    localparam state_t ST_SETTLE = 4'd8;
    localparam state_t ST_R2A    = 4'd9;
    localparam state_t ST_R2B    = 4'd10;
    localparam state_t ST_R2C    = 4'd11;
    localparam state_t ST_R2D    = 4'd12;
    localparam state_t ST_R2E    = 4'd13;
    localparam state_t ST_EMIT   = 4'd14;

    localparam emit_idx_t EMIT_LAST = 2'd3;

endpackage

// File: rtl/core/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer with its sequencer and shared datapath.
`timescale 1ns / 1ps

// A start word loads the center and radii and produces the four mirrored points of
// (0, radius_y); each step word advances the midpoint walk by one iteration and produces
// the four mirrored points of the new offset, one point per cycle while out_ready is high.
// The block takes one word at a time and is ready only between words. A start word runs
// its setup (four products through the one registered multiplier) before its points.
// A step word runs its offset update, two decision accumulations and slope test before
// its points. Any word, start or step, that leaves region 1 with y still above zero adds
// the five products of the region 2 decision value.
// A step word while idle or done is taken and produces nothing.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [COORD_BITS-1:0]          center_x,
    input  logic [COORD_BITS-1:0]          center_y,
    input  logic [RADIUS_BITS-1:0]         radius_x,
    input  logic [RADIUS_BITS-1:0]         radius_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [COORD_BITS+1:0]   point_x,
    output logic signed [COORD_BITS+1:0]   point_y,
    output logic                           last_of_step,
    output logic                           figure_done
);

    localparam int OUT_W = COORD_BITS + 2;
    localparam int SQ_W  = 2 * RADIUS_BITS;
    localparam int ST_W  = 3 * RADIUS_BITS + 7;
    localparam int CMP_W = ST_W + 2;
    localparam int DEC_W = 4 * RADIUS_BITS + 8;
    localparam int MA_W  = (SQ_W > COORD_BITS + 1) ? SQ_W : COORD_BITS + 1;
    localparam int MB_W  = (SQ_W > 2 * COORD_BITS + 2) ? SQ_W : 2 * COORD_BITS + 2;
    localparam int P_W   = MA_W + MB_W;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    emit_idx_t               emit_idx_reg, emit_idx_next;
    logic                    add_x_reg, add_x_next;
    logic                    sub_y_reg, sub_y_next;

    logic [COORD_BITS-1:0]   cx_reg, cx_next;
    logic [COORD_BITS-1:0]   cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]  ry_reg, ry_next;
    logic [COORD_BITS-1:0]   x_reg, x_next;
    logic [COORD_BITS-1:0]   y_reg, y_next;
    logic [SQ_W-1:0]         a2_reg, a2_next;
    logic [SQ_W-1:0]         b2_reg, b2_next;
    logic [ST_W-1:0]         stx_reg, stx_next;
    logic [ST_W-1:0]         sty_reg, sty_next;
    logic [DEC_W-1:0]        dec_reg, dec_next;
    logic [P_W-1:0]          prod_reg;

    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [DEC_W-1:0]        dec_base;
    logic [DEC_W-1:0]        dec_mag;
    logic                    dec_sub;

    logic [DEC_W-1:0]        prod_ext;
    logic [DEC_W-1:0]        prod_x4;
    logic [DEC_W-1:0]        a2_x4;
    logic [DEC_W-1:0]        b2_x4;
    logic [DEC_W-1:0]        stx_x4;
    logic [DEC_W-1:0]        sty_x4;
    logic [CMP_W-1:0]        slope_rhs;
    logic [COORD_BITS:0]     t_val;
    logic [COORD_BITS-1:0]   ym_val;
    logic                    dec_neg;
    logic                    dec_zero;

    logic [OUT_W-1:0]        px_pos, px_neg, py_pos, py_neg;

    assign prod_ext  = DEC_W'(prod_reg);
    assign prod_x4   = {prod_ext[DEC_W-3:0], 2'b00};
    assign a2_x4     = DEC_W'({a2_reg, 2'b00});
    assign b2_x4     = DEC_W'({b2_reg, 2'b00});
    assign stx_x4    = DEC_W'({stx_reg, 2'b00});
    assign sty_x4    = DEC_W'({sty_reg, 2'b00});
    assign slope_rhs = CMP_W'(stx_reg) + CMP_W'({b2_reg, 1'b0}) + CMP_W'(a2_reg);
    assign t_val     = {x_reg, 1'b1};
    assign ym_val    = y_reg - COORD_BITS'(1);
    assign dec_neg   = dec_reg[DEC_W-1];
    assign dec_zero  = (dec_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        emit_idx_next = emit_idx_reg;
        add_x_next    = add_x_reg;
        sub_y_next    = sub_y_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        ry_next       = ry_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        a2_next       = a2_reg;
        b2_next       = b2_reg;
        stx_next      = stx_reg;
        sty_next      = sty_reg;
        mul_a         = '0;
        mul_b         = '0;
        dec_base      = dec_reg;
        dec_mag       = '0;
        dec_sub       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                emit_idx_next = '0;
                if (in_valid)
                begin
                    if (opcode == OP_START)
                    begin
                        cx_next    = center_x;
                        cy_next    = center_y;
                        ry_next    = radius_y;
                        x_next     = '0;
                        y_next     = COORD_BITS'(radius_y);
                        mul_a      = MA_W'(radius_x);
                        mul_b      = MB_W'(radius_x);
                        state_next = ST_SQX;
                    end
                    else if (phase_reg inside {PH_R1, PH_R2})
                    begin
                        add_x_next = (phase_reg == PH_R1) || dec_neg || dec_zero;
                        sub_y_next = (phase_reg == PH_R2) || !dec_neg;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_SQX:
            begin
                a2_next    = SQ_W'(prod_reg);
                mul_a      = MA_W'(ry_reg);
                mul_b      = MB_W'(ry_reg);
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                b2_next    = SQ_W'(prod_reg);
                dec_base   = '0;
                dec_mag    = DEC_W'(a2_reg);
                mul_a      = MA_W'(a2_reg);
                mul_b      = MB_W'(ry_reg);
                state_next = ST_ARY;
            end
            ST_ARY:
            begin
                dec_mag    = prod_x4;
                dec_sub    = 1'b1;
                mul_a      = MA_W'(a2_reg);
                mul_b      = MB_W'(y_reg);
                state_next = ST_AOY;
            end
            ST_AOY:
            begin
                sty_next   = ST_W'({prod_reg, 1'b0});
                stx_next   = '0;
                dec_mag    = b2_x4;
                phase_next = PH_R1;
                state_next = ST_SETTLE;
            end
            ST_UPD:
            begin
                if (add_x_reg)
                begin
                    x_next   = x_reg + COORD_BITS'(1);
                    stx_next = stx_reg + ST_W'({b2_reg, 1'b0});
                end
                if (sub_y_reg)
                begin
                    y_next   = y_reg - COORD_BITS'(1);
                    sty_next = sty_reg - ST_W'({a2_reg, 1'b0});
                end
                dec_mag    = (phase_reg == PH_R1) ? b2_x4 : a2_x4;
                state_next = ST_ADDX;
            end
            ST_ADDX:
            begin
                if (add_x_reg)
                begin
                    dec_mag = stx_x4;
                end
                state_next = ST_SUBY;
            end
            ST_SUBY:
            begin
                if (sub_y_reg)
                begin
                    dec_mag = sty_x4;
                    dec_sub = 1'b1;
                end
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                state_next = ST_EMIT;
                if (phase_reg == PH_R1)
                begin
                    // The region 1 slope test, rewritten on the running step terms.
                    if (CMP_W'(sty_reg) <= slope_rhs)
                    begin
                        if (y_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_R2;
                            mul_a      = MA_W'(t_val);
                            mul_b      = MB_W'(t_val);
                            state_next = ST_R2A;
                        end
                    end
                end
                else if (y_reg == '0)
                begin
                    phase_next = PH_DONE;
                end
            end
            ST_R2A:
            begin
                mul_a      = MA_W'(b2_reg);
                mul_b      = MB_W'(prod_reg);
                state_next = ST_R2B;
            end
            ST_R2B:
            begin
                dec_base   = '0;
                dec_mag    = prod_ext;
                mul_a      = MA_W'(a2_reg);
                mul_b      = MB_W'(b2_reg);
                state_next = ST_R2C;
            end
            ST_R2C:
            begin
                dec_mag    = prod_x4;
                dec_sub    = 1'b1;
                mul_a      = MA_W'(ym_val);
                mul_b      = MB_W'(ym_val);
                state_next = ST_R2D;
            end
            ST_R2D:
            begin
                mul_a      = MA_W'(a2_reg);
                mul_b      = MB_W'(prod_reg);
                state_next = ST_R2E;
            end
            ST_R2E:
            begin
                dec_mag    = prod_x4;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    emit_idx_next = emit_idx_reg + emit_idx_t'(1);
                    if (emit_idx_reg == EMIT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        dec_next = dec_sub ? (dec_base - dec_mag) : (dec_base + dec_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_IDLE;
            emit_idx_reg <= '0;
            add_x_reg    <= 1'b0;
            sub_y_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            emit_idx_reg <= emit_idx_next;
            add_x_reg    <= add_x_next;
            sub_y_reg    <= sub_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        ry_reg   <= ry_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        a2_reg   <= a2_next;
        b2_reg   <= b2_next;
        stx_reg  <= stx_next;
        sty_reg  <= sty_next;
        dec_reg  <= dec_next;
        prod_reg <= P_W'(mul_a) * P_W'(mul_b);
    end

    assign px_pos = OUT_W'(cx_reg) + OUT_W'(x_reg);
    assign px_neg = OUT_W'(cx_reg) - OUT_W'(x_reg);
    assign py_pos = OUT_W'(cy_reg) + OUT_W'(y_reg);
    assign py_neg = OUT_W'(cy_reg) - OUT_W'(y_reg);

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_EMIT);
    assign point_x      = emit_idx_reg[0] ? px_neg : px_pos;
    assign point_y      = emit_idx_reg[1] ? py_neg : py_pos;
    assign last_of_step = (emit_idx_reg == EMIT_LAST);
    assign figure_done  = (phase_reg == PH_DONE);

`ifndef SYNTH
    a_emit_has_figure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase_reg != PH_IDLE)
        else $error("Points are offered while no figure is loaded.");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_step |=> in_ready && !out_valid)
        else $error("The block did not return to ready after the last point.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_START |=> !in_ready && !out_valid)
        else $error("A start word did not enter its setup sequence.");
`endif

endmodule
